FILE: rtl/core/wpsp_pkg.sv
package wpsp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_RIFF    = 3'd1;
   localparam logic [2:0] ERR_WAVE    = 3'd2;
   localparam logic [2:0] ERR_FMT     = 3'd3;
   localparam logic [2:0] ERR_NOT_PCM = 3'd4;
   localparam logic [2:0] ERR_DATA    = 3'd5;
   localparam logic [2:0] ERR_FORMAT  = 3'd6;

   // Chunk tags as they sit in the little-endian shift register
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [15:0] FORMAT_PCM = 16'd1;
   localparam logic [7:0]  PCM_OFFSET = 8'd128;

   // Header byte offsets where a field is complete
   localparam logic [5:0] OFF_RIFF     = 6'd3;
   localparam logic [5:0] OFF_WAVE     = 6'd11;
   localparam logic [5:0] OFF_FMT      = 6'd15;
   localparam logic [5:0] OFF_FORMAT   = 6'd21;
   localparam logic [5:0] OFF_CHANNELS = 6'd23;
   localparam logic [5:0] OFF_RATE     = 6'd27;
   localparam logic [5:0] OFF_BITS     = 6'd35;
   localparam logic [5:0] OFF_DATA     = 6'd39;
   localparam logic [5:0] OFF_LAST     = 6'd43;

   // Frame size is channels times 1, 2 or 4 bytes
   localparam int DIVISOR_WIDTH = 18;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         error_code;
      logic [15:0]        channel_count;
      logic [31:0]        sample_rate;
      logic [15:0]        sample_bits;
      logic [31:0]        frame_total;
      logic [15:0]        channel_index;
      logic [31:0]        frame_index;
      logic signed [31:0] sample_value;
      logic               last;
   } result_type;

   typedef struct packed {
      logic                     start;
      logic                     ack;
      logic [31:0]              dividend;
      logic [DIVISOR_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [31:0]              quotient;
      logic [DIVISOR_WIDTH-1:0] remainder;
   } div_rsp_type;

   // Supported bit depths: 8, 16 and 32
   function automatic logic depth_ok(input logic [15:0] bits);
      depth_ok = (bits == 16'd8) || (bits == 16'd16) || (bits == 16'd32);
   endfunction

   // log2 of the bytes per sample
   function automatic logic [1:0] depth_log2(input logic [15:0] bits);
      case (bits)
         16'd16:  depth_log2 = 2'd1;
         16'd32:  depth_log2 = 2'd2;
         default: depth_log2 = 2'd0;
      endcase
   endfunction

endpackage

FILE: rtl/core/wpsp_frame_divider.sv
module wpsp_frame_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wpsp_pkg::div_req_type div_req,
   output wpsp_pkg::div_rsp_type div_rsp
);
   import wpsp_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [4:0]               count_ff, count_in;
   logic [31:0]              quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   // One restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         count_in   = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[30:0], fits};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: rtl/core/wpsp_parse_core.sv
module wpsp_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            byte_in,
   input  logic                  restart,
   input  logic                  queue_full,
   output logic                  busy,
   output logic                  push,
   output wpsp_pkg::result_type  push_data,
   output wpsp_pkg::div_req_type div_req,
   input  wpsp_pkg::div_rsp_type div_rsp
);
   import wpsp_pkg::*;

   typedef enum logic [1:0] {
      MODE_HEADER,
      MODE_DATA,
      MODE_IDLE,
      MODE_DIVIDE
   } mode_type;

   mode_type    mode_ff, mode_in, base_mode;
   logic [5:0]  offset_ff, offset_in, base_offset;
   logic [31:0] shift_ff, shift_in, base_shift, shift_new;
   logic [15:0] channels_ff, channels_in, base_channels;
   logic [31:0] rate_ff, rate_in, base_rate;
   logic [15:0] bits_ff, bits_in, base_bits;
   logic [31:0] remain_ff, remain_in, base_remain;
   logic [1:0]  count_ff, count_in, base_count;
   logic [23:0] assembly_ff, assembly_in, base_assembly;
   logic [15:0] chan_ff, chan_in, base_chan, chan_next;
   logic [31:0] frame_ff, frame_in, base_frame;
   logic [1:0]  lg;
   logic        sample_done;

   // Restart clears the parser before the byte is taken
   always_comb begin
      if (restart) begin
         base_mode     = MODE_HEADER;
         base_offset   = '0;
         base_shift    = '0;
         base_channels = '0;
         base_rate     = '0;
         base_bits     = '0;
         base_remain   = '0;
         base_count    = '0;
         base_assembly = '0;
         base_chan     = '0;
         base_frame    = '0;
      end else begin
         base_mode     = mode_ff;
         base_offset   = offset_ff;
         base_shift    = shift_ff;
         base_channels = channels_ff;
         base_rate     = rate_ff;
         base_bits     = bits_ff;
         base_remain   = remain_ff;
         base_count    = count_ff;
         base_assembly = assembly_ff;
         base_chan     = chan_ff;
         base_frame    = frame_ff;
      end
   end

   assign shift_new = {byte_in, base_shift[31:8]};
   assign lg        = depth_log2(base_bits);
   assign chan_next = base_chan + 16'd1;

   // Final byte of a sample for the current depth
   always_comb begin
      case (lg)
         2'd0:    sample_done = 1'b1;
         2'd1:    sample_done = (base_count == 2'd1);
         default: sample_done = (base_count == 2'd3);
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      offset_in   = offset_ff;
      shift_in    = shift_ff;
      channels_in = channels_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      remain_in   = remain_ff;
      count_in    = count_ff;
      assembly_in = assembly_ff;
      chan_in     = chan_ff;
      frame_in    = frame_ff;
      push        = 1'b0;
      push_data   = '0;
      div_req.start    = 1'b0;
      div_req.ack      = 1'b0;
      div_req.dividend = shift_new;
      div_req.divisor  = {2'b00, base_channels} << lg;

      if (mode_ff == MODE_DIVIDE) begin
         // Emit the header once the frame count is known and there is room
         if (div_rsp.done && !queue_full) begin
            div_req.ack  = 1'b1;
            push         = 1'b1;
            push_data.kind          = KIND_HEADER;
            push_data.channel_count = channels_ff;
            push_data.sample_rate   = rate_ff;
            push_data.sample_bits   = bits_ff;
            push_data.frame_total   = div_rsp.quotient;
            remain_in   = shift_ff - {14'd0, div_rsp.remainder};
            count_in    = '0;
            assembly_in = '0;
            chan_in     = '0;
            frame_in    = '0;
            mode_in     = (div_rsp.quotient != 32'd0) ? MODE_DATA : MODE_IDLE;
         end
      end else if (take) begin
         mode_in     = base_mode;
         offset_in   = base_offset;
         shift_in    = base_shift;
         channels_in = base_channels;
         rate_in     = base_rate;
         bits_in     = base_bits;
         remain_in   = base_remain;
         count_in    = base_count;
         assembly_in = base_assembly;
         chan_in     = base_chan;
         frame_in    = base_frame;
         case (base_mode)
            MODE_HEADER: begin
               shift_in = shift_new;
               if (base_offset < OFF_LAST) begin
                  offset_in = base_offset + 6'd1;
               end
               push_data.kind = KIND_ERROR;
               case (base_offset)
                  OFF_RIFF: begin
                     if (shift_new != TAG_RIFF) begin
                        push = 1'b1;
                        push_data.error_code = ERR_RIFF;
                     end
                  end
                  OFF_WAVE: begin
                     if (shift_new != TAG_WAVE) begin
                        push = 1'b1;
                        push_data.error_code = ERR_WAVE;
                     end
                  end
                  OFF_FMT: begin
                     if (shift_new != TAG_FMT) begin
                        push = 1'b1;
                        push_data.error_code = ERR_FMT;
                     end
                  end
                  OFF_FORMAT: begin
                     if (shift_new[31:16] != FORMAT_PCM) begin
                        push = 1'b1;
                        push_data.error_code = ERR_NOT_PCM;
                     end
                  end
                  OFF_CHANNELS: channels_in = shift_new[31:16];
                  OFF_RATE:     rate_in = shift_new;
                  OFF_BITS:     bits_in = shift_new[31:16];
                  OFF_DATA: begin
                     if (shift_new != TAG_DATA) begin
                        push = 1'b1;
                        push_data.error_code = ERR_DATA;
                     end
                  end
                  OFF_LAST: begin
                     if (base_channels == 16'd0 || !depth_ok(base_bits)) begin
                        push = 1'b1;
                        push_data.error_code = ERR_FORMAT;
                     end else begin
                        div_req.start = 1'b1;
                        mode_in = MODE_DIVIDE;
                     end
                  end
                  default: ;
               endcase
               // Any error parks the parser until restart
               if (push) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DATA: begin
               if (base_remain == 32'd0) begin
                  mode_in = MODE_IDLE;
               end else begin
                  remain_in = base_remain - 32'd1;
                  if (!sample_done) begin
                     // Collect a low byte of a multi-byte sample
                     case (base_count)
                        2'd0:    assembly_in = {base_assembly[23:8], byte_in};
                        2'd1:    assembly_in = {base_assembly[23:16], byte_in,
                                                base_assembly[7:0]};
                        default: assembly_in = {byte_in, base_assembly[15:0]};
                     endcase
                     count_in = base_count + 2'd1;
                  end else begin
                     push = 1'b1;
                     push_data.kind          = KIND_SAMPLE;
                     push_data.channel_index = base_chan;
                     push_data.frame_index   = base_frame;
                     push_data.last          = (base_remain == 32'd1);
                     case (lg)
                        2'd0:    push_data.sample_value = {byte_in ^ PCM_OFFSET, 24'd0};
                        2'd1:    push_data.sample_value = {byte_in, base_assembly[7:0],
                                                           16'd0};
                        default: push_data.sample_value = {byte_in, base_assembly};
                     endcase
                     assembly_in = '0;
                     count_in    = '0;
                     // Advance channel, wrap into the next frame
                     if (chan_next >= base_channels) begin
                        chan_in  = '0;
                        frame_in = base_frame + 32'd1;
                     end else begin
                        chan_in = chan_next;
                     end
                     if (base_remain == 32'd1) begin
                        mode_in = MODE_IDLE;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         offset_ff   <= '0;
         shift_ff    <= '0;
         channels_ff <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         remain_ff   <= '0;
         count_ff    <= '0;
         assembly_ff <= '0;
         chan_ff     <= '0;
         frame_ff    <= '0;
      end else begin
         mode_ff     <= mode_in;
         offset_ff   <= offset_in;
         shift_ff    <= shift_in;
         channels_ff <= channels_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         remain_ff   <= remain_in;
         count_ff    <= count_in;
         assembly_ff <= assembly_in;
         chan_ff     <= chan_in;
         frame_ff    <= frame_in;
      end
   end

   assign busy = (mode_ff == MODE_DIVIDE);

endmodule

FILE: rtl/core/wpsp_result_queue.sv
module wpsp_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wpsp_pkg::result_type push_data,
   input  logic                 out_stall,
   output logic                 out_valid,
   output wpsp_pkg::result_type out_data,
   output logic                 full
);
   import wpsp_pkg::*;

   result_type slot_ff [2];
   logic [1:0] count_ff;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && !out_stall;
   assign out_data  = slot_ff[rd_ptr_ff];

   // Write the new transaction behind any that still waits
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/core/wav_pcm_stream_parser_unit.sv
// Channel  | Direction | Handshake          | Payload
// req      | in        | req_valid/req_stall| req_byte_in, req_restart
// rsp      | out       | rsp_valid/rsp_stall| rsp_kind ... rsp_last (one transaction per result)
//
// One file byte is taken per cycle unless req_stall is high; each result goes to the queue.
// After header byte 43 the frame count comes from a 1-bit-per-cycle divider:
// input is held until the header result is queued.
// Reset is synchronous and returns the parser to the header phase.
// A two-entry result queue absorbs rsp_stall; input stalls once both entries are occupied.
module wav_pcm_stream_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_byte_in,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_error_code,
   output logic [15:0]        rsp_channel_count,
   output logic [31:0]        rsp_sample_rate,
   output logic [15:0]        rsp_sample_bits,
   output logic [31:0]        rsp_frame_total,
   output logic [15:0]        rsp_channel_index,
   output logic [31:0]        rsp_frame_index,
   output logic signed [31:0] rsp_sample_value,
   output logic               rsp_last
);
   import wpsp_pkg::*;

   logic        take;
   logic        core_busy;
   logic        queue_full;
   logic        push;
   result_type  push_data;
   result_type  out_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Hold input while the queue is full or the frame count is being worked out
   assign req_stall = queue_full || core_busy;
   assign take      = req_valid && !req_stall;

   wpsp_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .byte_in    (req_byte_in),
      .restart    (req_restart),
      .queue_full (queue_full),
      .busy       (core_busy),
      .push       (push),
      .push_data  (push_data),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   wpsp_frame_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   wpsp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (queue_full)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_error_code    = out_data.error_code;
   assign rsp_channel_count = out_data.channel_count;
   assign rsp_sample_rate   = out_data.sample_rate;
   assign rsp_sample_bits   = out_data.sample_bits;
   assign rsp_frame_total   = out_data.frame_total;
   assign rsp_channel_index = out_data.channel_index;
   assign rsp_frame_index   = out_data.frame_index;
   assign rsp_sample_value  = out_data.sample_value;
   assign rsp_last          = out_data.last;

endmodule
